[hw/rtl/tso_pkg.sv]
// Shared types and constants for the table sine oscillator.
// No dependencies; imported by tso_sine_rom, table_sine_oscillator_unit and the testbench.
`default_nettype none

package tso_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int PHASE_W   = 32;
    localparam int REG_IDX_W = 3;

    // Register map
    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_SHIFT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DC_OFFSET   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_START_PHASE = 3'd4;

    localparam logic signed [SAMPLE_W-1:0] AMPLITUDE_RESET = 16'sd16384;

    // Request kinds carried in the input beat's tuser
    typedef enum logic [1:0] {
        REQ_GEN   = 2'd0,
        REQ_MUL   = 2'd1,
        REQ_MAC   = 2'd2,
        REQ_RESET = 2'd3
    } req_t;

    // Q30 constants for building the sine table
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

`default_nettype wire

[hw/rtl/tso_sine_rom.sv]
// Sine lookup ROM, TABLE_SIZE entries of signed Q1.15, registered read.
// Contents built at elaboration from a Q30 Taylor series; uses tso_pkg.
`default_nettype none

module tso_sine_rom
    import tso_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
) (
    input  wire logic                              clk,
    input  wire logic [$clog2(TABLE_SIZE)-1:0]     addr,
    output logic signed [SAMPLE_W-1:0]             data
);

    typedef logic signed [SAMPLE_W-1:0] rom_t [TABLE_SIZE];

    // One entry: 32767 * sin(2*pi*k/TABLE_SIZE), quadrant folded, Q30 series to x^11
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0]        u;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [1:0]         quad;
        logic signed [63:0] sum;
        logic signed [63:0] e;
        u    = {32'(k), 32'd0} / 64'(TABLE_SIZE);
        quad = u[31:30];
        r    = u & (Q30_ONE - 64'd1);
        if (quad[0])
            r = Q30_ONE - r;
        x    = (r * HALF_PI_Q30) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 5; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        e = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
        if (e > 64'sd32767)
            e = 64'sd32767;
        if (quad[1])
            e = -e;
        return SAMPLE_W'(e);
    endfunction

    function automatic rom_t build_rom();
        rom_t tbl;
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            tbl[k] = sine_entry(k);
        end
        return tbl;
    endfunction

    localparam rom_t ROM_INIT = build_rom();

    logic signed [SAMPLE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= ROM_INIT[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

[hw/rtl/table_sine_oscillator_unit.sv]
// Table sine oscillator (NCO with sine ROM and linear interpolation).
// Top level; uses tso_pkg and tso_sine_rom.
//
// Usage notes:
//  - Input stream s_axis_*: one beat is one sample tick. tuser carries the
//    request kind (generate, multiply, multiply-accumulate, phase reset),
//    tdata carries sample_in and acc_in.
//  - Output stream m_axis_*: one beat per input beat, tdata = sample_out,
//    tuser = saturated flag.
//  - Config channel cfg_*: index selects phase_step, phase_shift, amplitude,
//    dc_offset, start_phase; cfg_ready is always high. Writing start_phase
//    also loads the phase accumulator. Unknown indexes are dropped.
//  - One signed 34x17 multiplier (default parameters) is shared under a small
//    sequencer for the index product, interpolation, gain and sample product,
//    and the ROM is read twice through its single registered port.
//    s_axis_tready is high only while the sequencer is idle, so a new beat is
//    taken only once the previous item has been loaded into the output register.
//  - The result sits in an output register; the sequencer takes a new
//    beat while it waits. A stalled receiver only holds up the sequencer
//    when the next result is ready and the register is still full.
//  - Reset (rst_n low, async) loads config defaults (amplitude = 1.0),
//    zeroes the phase and empties the output register.
`default_nettype none

module table_sine_oscillator_unit
    import tso_pkg::*;
#(
    parameter int TABLE_SIZE = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [31:0]          s_axis_tdata,  // [15:0] sample_in, [31:16] acc_in
    input  wire logic [1:0]           s_axis_tuser,  // [1:0] req_type
    // output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [15:0]               m_axis_tdata,  // [15:0] sample_out
    output logic                      m_axis_tuser,  // [0] saturated
    // config write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [PHASE_W-1:0]   cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int MA_W   = PHASE_W + 2;
    localparam int MB_W   = (FRAC_BITS + 1 > SAMPLE_W + 1) ? FRAC_BITS + 1 : SAMPLE_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int S_W    = SAMPLE_W + 1;   // interpolated sample
    localparam int V_W    = SAMPLE_W + 3;   // scaled + offset, unclipped
    localparam int R_W    = 21;             // rounded sample product
    localparam int Y_W    = 22;             // final pre-saturation result

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INDEX,
        ST_ROM_A,
        ST_ROM_B,
        ST_INTERP,
        ST_SUM,
        ST_SCALE,
        ST_OFFSET,
        ST_MIX,
        ST_OUT
    } state_t;

    // control / config
    state_t                      state_reg;
    logic [PHASE_W-1:0]          phase_step_reg;
    logic [PHASE_W-1:0]          phase_shift_reg;
    logic signed [SAMPLE_W-1:0]  amplitude_reg;
    logic signed [SAMPLE_W-1:0]  dc_offset_reg;
    logic [PHASE_W-1:0]          phase_acc_reg;
    logic                        m_valid_reg;
    logic [SAMPLE_W-1:0]         m_data_reg;
    logic                        m_sat_reg;

    // datapath
    logic [PHASE_W-1:0]          p_reg;
    req_t                        req_reg;
    logic signed [SAMPLE_W-1:0]  smp_reg;
    logic signed [SAMPLE_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [FRAC_BITS-1:0]        frac_reg;
    logic signed [SAMPLE_W-1:0]  a_reg;
    logic signed [S_W-1:0]       s_reg;
    logic signed [V_W-1:0]       v_reg;

    logic                        in_beat;
    logic                        cfg_beat;
    logic                        out_load;
    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]    prod_next;
    logic [IDX_W-1:0]            rom_addr;
    logic signed [SAMPLE_W-1:0]  rom_data;
    logic [IDX_W-1:0]            nxt_idx;
    logic signed [S_W-1:0]       diff;
    logic signed [S_W-1:0]       s_next;
    logic signed [31:0]          gain_rnd;
    logic signed [V_W-1:0]       v_next;
    logic signed [35:0]          mix_rnd;
    logic signed [R_W-1:0]       r_val;
    logic signed [Y_W-1:0]       y_next;
    logic [SAMPLE_W-1:0]         y_sat;
    logic                        sat_next;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign cfg_beat      = cfg_valid && cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_sat_reg;

    // Shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_INDEX:
            begin
                mul_a = $signed({2'b00, p_reg});
                mul_b = $signed(MB_W'(TABLE_SIZE));
            end
            ST_INTERP:
            begin
                mul_a = MA_W'(diff);
                mul_b = $signed({{(MB_W - FRAC_BITS){1'b0}}, frac_reg});
            end
            ST_SCALE:
            begin
                mul_a = MA_W'(s_reg);
                mul_b = MB_W'(amplitude_reg);
            end
            ST_MIX:
            begin
                mul_a = MA_W'(v_reg);
                mul_b = MB_W'(smp_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // operands sign-extended to the product width; the core stays MA_W x MB_W
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // ROM port: index first, then its wrapped neighbor
    assign nxt_idx  = (idx_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_reg + 1'b1;
    assign rom_addr = (state_reg == ST_ROM_B) ? nxt_idx : prod_reg[32 +: IDX_W];

    tso_sine_rom #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // b - a, then a + floor((b - a) * frac / 2^FRAC_BITS)
    assign diff     = S_W'(rom_data) - S_W'(a_reg);
    assign s_next   = S_W'(a_reg) + S_W'(prod_reg >>> FRAC_BITS);

    // round gain product by 2^14, add DC
    assign gain_rnd = $signed(prod_reg[31:0]) + 32'sd8192;
    assign v_next   = V_W'(gain_rnd >>> 14) + V_W'(dc_offset_reg);

    // round sample product by 2^15
    assign mix_rnd  = $signed(prod_reg[35:0]) + 36'sd16384;
    assign r_val    = R_W'(mix_rnd >>> 15);

    always_comb
    begin
        case (req_reg)
            REQ_GEN:   y_next = Y_W'(v_reg);
            REQ_MUL:   y_next = Y_W'(r_val);
            REQ_MAC:   y_next = Y_W'(r_val) + Y_W'(acc_reg);
            REQ_RESET: y_next = '0;
            default:   y_next = '0;
        endcase
    end

    always_comb
    begin
        if (y_next > 22'sd32767)
        begin
            y_sat    = 16'h7fff;
            sat_next = 1'b1;
        end
        else if (y_next < -22'sd32768)
        begin
            y_sat    = 16'h8000;
            sat_next = 1'b1;
        end
        else
        begin
            y_sat    = y_next[SAMPLE_W-1:0];
            sat_next = 1'b0;
        end
    end

    // Sequencer, config registers, phase accumulator, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_step_reg  <= '0;
            phase_shift_reg <= '0;
            amplitude_reg   <= AMPLITUDE_RESET;
            dc_offset_reg   <= '0;
            phase_acc_reg   <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
            m_sat_reg       <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= y_sat;
                m_sat_reg   <= sat_next;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            // start_phase write loads the accumulator; otherwise the phase
            // moves or clears on accept (the tick has already latched its phase).
            if (cfg_beat && cfg_index == REG_START_PHASE)
                phase_acc_reg <= cfg_data;
            else if (in_beat)
            begin
                if (req_t'(s_axis_tuser) == REQ_RESET)
                    phase_acc_reg <= '0;
                else
                    phase_acc_reg <= phase_acc_reg + phase_step_reg;
            end

            if (cfg_beat)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:  phase_step_reg  <= cfg_data;
                    REG_PHASE_SHIFT: phase_shift_reg <= cfg_data;
                    REG_AMPLITUDE:   amplitude_reg   <= $signed(cfg_data[SAMPLE_W-1:0]);
                    REG_DC_OFFSET:   dc_offset_reg   <= $signed(cfg_data[SAMPLE_W-1:0]);
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        if (req_t'(s_axis_tuser) == REQ_RESET)
                            state_reg <= ST_OUT;
                        else
                            state_reg <= ST_INDEX;
                    end
                end
                ST_INDEX:  state_reg <= ST_ROM_A;
                ST_ROM_A:  state_reg <= ST_ROM_B;
                ST_ROM_B:  state_reg <= ST_INTERP;
                ST_INTERP: state_reg <= ST_SUM;
                ST_SUM:    state_reg <= ST_SCALE;
                ST_SCALE:  state_reg <= ST_OFFSET;
                ST_OFFSET:
                begin
                    if (req_reg == REQ_GEN)
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_MIX;
                end
                ST_MIX:    state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            p_reg   <= phase_acc_reg + phase_shift_reg;
            req_reg <= req_t'(s_axis_tuser);
            smp_reg <= $signed(s_axis_tdata[15:0]);
            acc_reg <= $signed(s_axis_tdata[31:16]);
        end
        if (state_reg == ST_INDEX || state_reg == ST_INTERP ||
            state_reg == ST_SCALE || state_reg == ST_MIX)
            prod_reg <= prod_next;
        if (state_reg == ST_ROM_A)
        begin
            idx_reg  <= prod_reg[32 +: IDX_W];
            frac_reg <= prod_reg[32 - FRAC_BITS +: FRAC_BITS];
        end
        if (state_reg == ST_ROM_B)
            a_reg <= rom_data;
        if (state_reg == ST_SUM)
            s_reg <= s_next;
        if (state_reg == ST_OFFSET)
            v_reg <= v_next;
    end

    // Checks
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROM_A |->
            {1'b0, prod_reg[32 +: IDX_W]} < (IDX_W + 1)'(TABLE_SIZE))
        else $error("table index out of range");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000))
        else $error("saturated flag without rail value");

    a_reset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && req_reg == REQ_RESET) |=>
            (m_axis_tdata == 16'h0000 && !m_axis_tuser))
        else $error("phase reset beat not zero");

    a_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_axis_tuser == REQ_RESET &&
         !(cfg_beat && cfg_index == REG_START_PHASE)) |=> phase_acc_reg == '0)
        else $error("phase not cleared by reset request");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for table_sine_oscillator_unit: drives sample ticks and
// register writes, predicts each output sample and compares it beat by beat.
// Depends on tso_pkg and the oscillator RTL only.
`timescale 1ns / 1ps

module testbench
    import tso_pkg::*;
();

    localparam int TABLE_SIZE    = 1024;
    localparam int FRAC_BITS     = 16;
    localparam int SETTLE_CYCLES = 16;    // margin over a tick's trip through the sequencer
    localparam int HANG_LIMIT    = 2000;  // cycles without any beat before giving up
    localparam int RAND_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 190;

    // one input beat: request kind plus the two sample operands
    typedef struct packed {
        req_t               req;
        logic signed [15:0] sample_in;
        logic signed [15:0] acc_in;
    } tick_t;

    // one output beat
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               saturated;
    } osc_result_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // DUT ports, all inputs known from time zero
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;  // [15:0] sample_in, [31:16] acc_in
    logic [1:0]           s_axis_tuser = '0;  // [1:0] req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;       // [15:0] sample_out
    logic                 m_axis_tuser;       // [0] saturated
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [PHASE_W-1:0]   cfg_data = '0;

    table_sine_oscillator_unit #(
        .TABLE_SIZE (TABLE_SIZE),
        .FRAC_BITS  (FRAC_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Ticks waiting to go out, and output samples owed by the DUT (oldest first)
    tick_t       pending_ticks[$];
    osc_result_t owed_samples[$];

    // Idle knobs, percent of cycles; changed only at negedge by the sequence
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;

    int unsigned mismatch_count = 0;
    int unsigned result_no = 0;
    int unsigned stall_cycles = 0;

    // Shadow of the oscillator registers and phase accumulator, reset values
    logic [31:0]        step_reg   = '0;
    logic [31:0]        shift_reg  = '0;
    logic signed [15:0] gain_reg   = AMPLITUDE_RESET;
    logic signed [15:0] offset_reg = '0;
    logic [31:0]        osc_phase  = '0;

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Sine table entry k, 32767*sin(2*pi*k/TABLE_SIZE), built from a Q30
    // Taylor series in the first quadrant and mirrored into the others.
    function automatic longint sine_entry(input logic [31:0] k);
        logic [63:0] turn;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] term;
        logic [1:0]  quad;
        longint      total;
        longint      mag;
        turn = {k, 32'b0} / 64'(TABLE_SIZE);
        quad = turn[31:30];
        r = turn & (Q30_ONE - 64'd1);
        if (quad[0])
            r = Q30_ONE - r;
        x = (r * HALF_PI_Q30) >> 30;
        term = x;
        total = longint'(x);
        for (int n = 1; n <= 5; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                total -= longint'(term);
            else
                total += longint'(term);
        end
        if (total < 0)
            total = 0;
        mag = (total * 32767 + 64'sd536870912) >>> 30;
        if (mag > 32767)
            mag = 32767;
        return quad[1] ? -mag : mag;
    endfunction

    // Output sample for one tick; advances the shadow phase as the DUT does
    function automatic osc_result_t osc_predict(input tick_t tk);
        osc_result_t res;
        logic [31:0] ph;
        logic [31:0] idx;
        logic [31:0] nxt;
        logic [63:0] t;
        longint      frac;
        longint      a;
        longint      b;
        longint      s;
        longint      v;
        longint      prod;
        longint      y;
        res = '0;
        if (tk.req == REQ_RESET)
        begin
            // phase goes to zero and does not advance on this tick
            osc_phase = '0;
            return res;
        end
        ph = osc_phase + shift_reg;
        t = {32'b0, ph} * 64'(TABLE_SIZE);
        idx = t[63:32];
        if (idx >= TABLE_SIZE)
            idx = TABLE_SIZE - 1;
        nxt = (idx + 1 >= TABLE_SIZE) ? 32'd0 : idx + 1;
        frac = longint'((t >> (32 - FRAC_BITS)) & ((64'd1 << FRAC_BITS) - 64'd1));
        a = sine_entry(idx);
        b = sine_entry(nxt);
        s = a + (((b - a) * frac) >>> FRAC_BITS);
        // v stays wide: gain and offset may overflow 16 bits before the multiply
        v = ((s * longint'(gain_reg) + 64'sd8192) >>> 14) + longint'(offset_reg);
        prod = (longint'(tk.sample_in) * v + 64'sd16384) >>> 15;
        case (tk.req)
            REQ_GEN: y = v;
            REQ_MUL: y = prod;
            default: y = prod + longint'(tk.acc_in);
        endcase
        if (y > 32767)
        begin
            y = 32767;
            res.saturated = 1'b1;
        end
        else if (y < -32768)
        begin
            y = -32768;
            res.saturated = 1'b1;
        end
        res.sample_out = y[15:0];
        osc_phase = osc_phase + step_reg;
        return res;
    endfunction

    function automatic tick_t make_tick(input req_t r, input logic [15:0] smp,
                                        input logic [15:0] acc);
        tick_t tk;
        tk.req = r;
        tk.sample_in = smp;
        tk.acc_in = acc;
        return tk;
    endfunction

    // operand with a good share of edge values
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tick_t rand_tick();
        int unsigned pick;
        req_t        r;
        pick = $urandom_range(0, 9);
        // phase resets are kept rare so the phase gets to wander
        if (pick < 3)
            r = REQ_GEN;
        else if (pick < 6)
            r = REQ_MUL;
        else if (pick < 9)
            r = REQ_MAC;
        else
            r = REQ_RESET;
        return make_tick(r, rand_sample(), rand_sample());
    endfunction

    // Source side: hold a beat until taken, otherwise maybe present the next one
    always @(posedge clk)
    begin : feed_ticks
        tick_t beat;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                beat = pending_ticks.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {beat.acc_in, beat.sample_in};
                s_axis_tuser  <= beat.req;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Port monitor: tracks register writes, predicts on each accepted tick,
    // checks each accepted sample, and watches for a hang.
    always @(posedge clk)
    begin : watch_ports
        tick_t       seen;
        osc_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:  step_reg = cfg_data;
                    REG_PHASE_SHIFT: shift_reg = cfg_data;
                    REG_AMPLITUDE:   gain_reg = cfg_data[15:0];
                    REG_DC_OFFSET:   offset_reg = cfg_data[15:0];
                    // start_phase also reloads the accumulator right away
                    REG_START_PHASE: osc_phase = cfg_data;
                    default: ;  // unmapped index is dropped
                endcase
            end

            // check before predicting: a sample never leaves on its own tick's edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_samples.size() == 0)
                begin
                    flag_mismatch($sformatf("sample %0d arrived with nothing owed (%0d)",
                                            result_no, $signed(m_axis_tdata)));
                end
                else
                begin
                    want = owed_samples.pop_front();
                    if (m_axis_tdata !== want.sample_out)
                        flag_mismatch($sformatf("sample %0d: sample_out %0d, want %0d",
                                                result_no, $signed(m_axis_tdata),
                                                want.sample_out));
                    if (m_axis_tuser !== want.saturated)
                        flag_mismatch($sformatf("sample %0d: saturated %b, want %b",
                                                result_no, m_axis_tuser, want.saturated));
                end
                result_no++;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                seen.req = req_t'(s_axis_tuser);
                seen.sample_in = s_axis_tdata[15:0];
                seen.acc_in = s_axis_tdata[31:16];
                owed_samples.push_back(osc_predict(seen));
            end

            if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;

            if (stall_cycles >= HANG_LIMIT)
            begin
                $display("table_sine_oscillator_unit verification failed");
                $finish;
            end
        end
    end

    // Waits until every tick is out and every sample back, then lets the
    // sequencer settle. Returns on a negedge.
    task automatic quiesce();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || s_axis_tvalid || owed_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes every register, 16-bit ones with junk in the upper half, plus one
    // write to an unmapped index that must be dropped.
    task automatic program_osc(input logic [31:0] step, input logic [31:0] shift,
                               input logic [15:0] amp, input logic [15:0] dc,
                               input logic [31:0] start);
        logic [REG_IDX_W-1:0] spare_idx;
        spare_idx = REG_START_PHASE +
                    REG_IDX_W'($urandom_range(1, 2 ** REG_IDX_W - 1 - REG_START_PHASE));
        write_reg(REG_PHASE_STEP, step);
        write_reg(spare_idx, $urandom);
        write_reg(REG_PHASE_SHIFT, shift);
        write_reg(REG_AMPLITUDE, {16'($urandom), amp});
        write_reg(REG_DC_OFFSET, {16'($urandom), dc});
        write_reg(REG_START_PHASE, start);
    endtask

    // idle pattern per phase: none, source gaps, sink stalls, both light
    task automatic set_idle(input int unsigned mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
            default: begin src_idle_pct = 9; sink_stall_pct = 9; end
        endcase
    endtask

    initial
    begin
        int unsigned phase_no;
        int unsigned first_part;
        logic [31:0] step_v;
        logic [31:0] shift_v;
        logic [31:0] start_v;
        logic [15:0] amp_v;
        logic [15:0] dc_v;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset defaults (unity gain, zero phase, zero step)
        @(negedge clk);
        pending_ticks.push_back(make_tick(REQ_GEN, 16'h0000, 16'h0000));
        pending_ticks.push_back(make_tick(REQ_MUL, 16'h8000, 16'h0000));
        pending_ticks.push_back(make_tick(REQ_RESET, 16'h7FFF, 16'hFFFF));
        quiesce();

        // Directed: most negative gain with max offset overflows before the
        // multiply; start at the last table entry with a full fraction so the
        // interpolation wraps to entry zero; quarter-turn step hits the peaks.
        program_osc(32'h4000_0000, 32'h0000_0000, 16'h8000, 16'h7FFF, 32'hFFFF_FFC0);
        @(negedge clk);
        pending_ticks.push_back(make_tick(REQ_GEN, 16'h0000, 16'h0000));
        pending_ticks.push_back(make_tick(REQ_GEN, 16'h1234, 16'h4321));
        pending_ticks.push_back(make_tick(REQ_MUL, 16'h7FFF, 16'h0000));
        pending_ticks.push_back(make_tick(REQ_MAC, 16'h8000, 16'h8000));
        pending_ticks.push_back(make_tick(REQ_MAC, 16'h7FFF, 16'h7FFF));
        pending_ticks.push_back(make_tick(REQ_MUL, 16'h8000, 16'hFFFF));
        pending_ticks.push_back(make_tick(REQ_RESET, 16'hAAAA, 16'h5555));
        pending_ticks.push_back(make_tick(REQ_GEN, 16'hFFFF, 16'hFFFF));
        pending_ticks.push_back(make_tick(REQ_MAC, 16'h0000, 16'h5555));
        pending_ticks.push_back(make_tick(REQ_MAC, 16'hFFFF, 16'hAAAA));
        quiesce();

        // Directed: max gain, min offset, step of all ones (phase runs backward)
        program_osc(32'hFFFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 32'h3FFF_FFFF);
        @(negedge clk);
        pending_ticks.push_back(make_tick(REQ_GEN, 16'h0000, 16'h0000));
        pending_ticks.push_back(make_tick(REQ_MUL, 16'h8000, 16'h0000));
        pending_ticks.push_back(make_tick(REQ_MAC, 16'h8000, 16'h8000));
        pending_ticks.push_back(make_tick(REQ_MAC, 16'h7FFF, 16'h7FFF));
        pending_ticks.push_back(make_tick(REQ_GEN, 16'h5555, 16'hAAAA));
        pending_ticks.push_back(make_tick(REQ_RESET, 16'h0000, 16'h0000));
        pending_ticks.push_back(make_tick(REQ_GEN, 16'h0000, 16'h0000));
        pending_ticks.push_back(make_tick(REQ_MUL, 16'h5555, 16'hAAAA));
        quiesce();

        // Random phases: fresh settings and idle pattern each time
        for (phase_no = 0; phase_no < RAND_PHASES; phase_no++)
        begin
            step_v  = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
            shift_v = $urandom;
            start_v = $urandom;
            amp_v   = ($urandom_range(0, 3) == 0) ? AMPLITUDE_RESET : 16'($urandom);
            dc_v    = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
            case (phase_no)
                0:
                begin
                    step_v = 32'hFFFF_FFFF;
                    amp_v  = 16'h7FFF;
                    dc_v   = 16'h8000;
                end
                1:
                begin
                    step_v  = 32'h0000_0000;
                    shift_v = 32'hFFFF_FFFF;
                    start_v = 32'hFFFF_FFFF;
                    amp_v   = 16'h8000;
                    dc_v    = 16'h7FFF;
                end
                2: amp_v = 16'h0000;
                3:
                begin
                    amp_v = AMPLITUDE_RESET;
                    dc_v  = 16'h0000;
                end
                default: ;
            endcase
            program_osc(step_v, shift_v, amp_v, dc_v, start_v);

            @(negedge clk);
            set_idle(phase_no);
            first_part = $urandom_range(40, 150);
            repeat (first_part) pending_ticks.push_back(rand_tick());
            // hold the source until every owed sample is back
            quiesce();
            repeat (TICKS_PER_PHASE - first_part) pending_ticks.push_back(rand_tick());
            quiesce();
        end

        if (mismatch_count == 0)
            $display("table_sine_oscillator_unit verification clean");
        else
            $display("table_sine_oscillator_unit verification failed");
        $finish;
    end

endmodule
